[sv/c3lr_pkg.sv]
// ---------------------------------------------------------------------------
// c3lr_pkg: shared types and constants
// Commands, sequencer states and fixed-point constants for the 3x3 layer.
// ---------------------------------------------------------------------------
package c3lr_pkg;

	typedef enum logic [1:0] {
		CMD_PIXEL   = 2'd0,
		CMD_WEIGHT  = 2'd1,
		CMD_BIAS    = 2'd2,
		CMD_COMPUTE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_WIDTH      = 2'd0,
		REG_HEIGHT     = 2'd1,
		REG_IN_PLANES  = 2'd2,
		REG_OUT_PLANES = 2'd3
	} reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ACC,
		ST_BIAS,
		ST_ACT,
		ST_OUT
	} state_t;

	localparam int ACC_W     = 40;
	localparam int FRAC_BITS = 12;
	localparam int LEAK_NUM  = 6554;
	localparam int LEAK_SHIFT = 16;
	localparam int TAPS      = 9;

endpackage

[sv/c3lr_ram.sv]
// ---------------------------------------------------------------------------
// c3lr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module c3lr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/conv3x3_multiplane_leaky_relu.sv]
// ---------------------------------------------------------------------------
// conv3x3_multiplane_leaky_relu: 3x3 convolution layer with leaky rectifier
// Command-driven layer over pixel, weight and bias memories.
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one command per
// transfer. Pixel, weight and bias writes are stored on acceptance and
// give no result. A compute command for an output plane in use sums the
// nine taps (replicate padding at the frame edges) over all input planes
// in use, adds the bias, scales a negative sum by 6554/65536 and returns
// one saturated Q3.12 pixel on the output channel (out_valid/out_ready).
// Each kernel tap has its own copy of the pixel memory, and the weights are
// banked by tap, so one input plane is read per cycle.
// With N input planes in use (in_planes saturated to 1..MAX_IN_PLANES),
// a compute reads the N planes in ST_READ, waits in ST_ACC while the RAM
// read and product registers drain, adds the bias in ST_BIAS, applies the
// slope in ST_ACT and raises out_valid in ST_OUT. Items are handled one
// at a time. The result sits in an output register; while the receiver
// stalls, in_ready stays low. Reset clears the configuration to 64x64
// with one input and one output plane. The memories are not cleared:
// every entry must be written before use; the block does not enforce it.
// The configuration port (cfg_valid/cfg_ready) is always ready.
// ---------------------------------------------------------------------------
module conv3x3_multiplane_leaky_relu #(
	parameter int MAX_WIDTH      = 64,
	parameter int MAX_HEIGHT     = 64,
	parameter int MAX_IN_PLANES  = 32,
	parameter int MAX_OUT_PLANES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [4:0]         src_plane,
	input  logic [4:0]         dst_plane,
	input  logic [5:0]         col,
	input  logic [5:0]         row,
	input  logic [3:0]         tap,
	input  logic signed [15:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [4:0]         res_plane,
	output logic [5:0]         res_col,
	output logic [5:0]         res_row,
	output logic signed [15:0] pixel_out,
	output logic               saturated
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int IPW = (MAX_IN_PLANES > 1) ? $clog2(MAX_IN_PLANES) : 1;
	localparam int OPW = (MAX_OUT_PLANES > 1) ? $clog2(MAX_OUT_PLANES) : 1;
	localparam int PIX_DEPTH = MAX_IN_PLANES * MAX_HEIGHT * MAX_WIDTH;
	localparam int WT_DEPTH  = MAX_OUT_PLANES * MAX_IN_PLANES;
	localparam int PAW = $clog2(PIX_DEPTH);
	localparam int WAW = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
	localparam int BAW = OPW;
	localparam int BDEPTH = (MAX_OUT_PLANES > 1) ? MAX_OUT_PLANES : 2;
	localparam int WDEPTH = (WT_DEPTH > 1) ? WT_DEPTH : 2;
	localparam int ACC_W = c3lr_pkg::ACC_W;

	// Configuration registers.
	logic [6:0] width_q, height_q;
	logic [5:0] inp_q, outp_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
			inp_q    <= 6'd1;
			outp_q   <= 6'd1;
		end else if (cfg_valid) begin
			case (c3lr_pkg::reg_t'(cfg_index))
				c3lr_pkg::REG_WIDTH:      width_q  <= cfg_data;
				c3lr_pkg::REG_HEIGHT:     height_q <= cfg_data;
				c3lr_pkg::REG_IN_PLANES:  inp_q    <= cfg_data[5:0];
				c3lr_pkg::REG_OUT_PLANES: outp_q   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Effective (saturated) frame and plane counts.
	logic [10:0] w_eff, h_eff;
	logic [8:0]  np_eff;
	always_comb begin
		w_eff = (width_q == 7'd0) ? 11'd1 : 11'(width_q);
		if (w_eff > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
		h_eff = (height_q == 7'd0) ? 11'd1 : 11'(height_q);
		if (h_eff > 11'(MAX_HEIGHT)) h_eff = 11'(MAX_HEIGHT);
		np_eff = (inp_q == 6'd0) ? 9'd1 : 9'(inp_q);
		if (np_eff > 9'(MAX_IN_PLANES)) np_eff = 9'(MAX_IN_PLANES);
	end

	c3lr_pkg::state_t state_q, state_d;
	logic acc_in;
	assign acc_in = in_valid && in_ready;
	assign in_ready = (state_q == c3lr_pkg::ST_IDLE);

	logic is_pix, is_wt, is_bias, is_comp;
	assign is_pix  = acc_in && (command == c3lr_pkg::CMD_PIXEL) &&
		(32'(src_plane) < MAX_IN_PLANES) && (32'(row) < MAX_HEIGHT) &&
		(32'(col) < MAX_WIDTH);
	assign is_wt   = acc_in && (command == c3lr_pkg::CMD_WEIGHT) &&
		(32'(dst_plane) < MAX_OUT_PLANES) && (32'(src_plane) < MAX_IN_PLANES) &&
		(tap < 4'(c3lr_pkg::TAPS));
	assign is_bias = acc_in && (command == c3lr_pkg::CMD_BIAS) &&
		(32'(dst_plane) < MAX_OUT_PLANES);
	assign is_comp = acc_in && (command == c3lr_pkg::CMD_COMPUTE) &&
		(6'(dst_plane) < outp_q) && (32'(dst_plane) < MAX_OUT_PLANES);

	// Captured compute request and plane counter.
	logic [4:0] dst_q;
	logic [5:0] col_q, row_q;
	logic [8:0] plane_q;
	logic       last_s1;
	logic [XW-1:0] cx_q [3];
	logic [YW-1:0] cy_q [3];

	// Clamped tap coordinates, computed at acceptance.
	logic [XW-1:0] cx_d [3];
	logic [YW-1:0] cy_d [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [11:0] cc, rr;
			cc = $signed({6'd0, col}) + 12'(k) - 12'sd1;
			rr = $signed({6'd0, row}) + 12'(k) - 12'sd1;
			if (cc < 0) cc = 12'sd0;
			if (cc >= $signed({1'b0, w_eff})) cc = $signed({1'b0, w_eff}) - 12'sd1;
			if (rr < 0) rr = 12'sd0;
			if (rr >= $signed({1'b0, h_eff})) rr = $signed({1'b0, h_eff}) - 12'sd1;
			cx_d[k] = cc[XW-1:0];
			cy_d[k] = rr[YW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (is_comp) begin
			dst_q <= dst_plane;
			col_q <= col;
			row_q <= row;
			cx_q  <= cx_d;
			cy_q  <= cy_d;
		end
	end

	// Memory banks: nine pixel banks (one per tap) would need per-tap
	// addressing; instead each tap has its own copy of the pixel store.
	logic [15:0] pix_rd [9];
	logic [15:0] wt_rd  [9];
	logic [15:0] bias_rd;
	logic [IPW-1:0] plane_idx;
	assign plane_idx = plane_q[IPW-1:0];

	for (genvar t = 0; t < 9; t++) begin : g_tap
		logic [PAW-1:0] praddr, pwaddr;
		logic [WAW-1:0] wraddr, wwaddr;
		assign pwaddr = PAW'((32'(src_plane) * MAX_HEIGHT + 32'(row)) * MAX_WIDTH
			+ 32'(col));
		assign praddr = PAW'((32'(plane_idx) * MAX_HEIGHT + 32'(cy_q[t/3]))
			* MAX_WIDTH + 32'(cx_q[t%3]));
		assign wwaddr = WAW'(32'(dst_plane) * MAX_IN_PLANES + 32'(src_plane));
		assign wraddr = WAW'(32'(dst_q) * MAX_IN_PLANES + 32'(plane_idx));

		c3lr_ram #(.WIDTH(16), .DEPTH(PIX_DEPTH)) u_pix (
			.clk(clk), .we(is_pix), .waddr(pwaddr), .wdata(value),
			.raddr(praddr), .rdata(pix_rd[t]));
		c3lr_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_wt (
			.clk(clk), .we(is_wt && (tap == 4'(t))), .waddr(wwaddr),
			.wdata(value), .raddr(wraddr), .rdata(wt_rd[t]));
	end

	c3lr_ram #(.WIDTH(16), .DEPTH(BDEPTH)) u_bias (
		.clk(clk), .we(is_bias), .waddr(BAW'(dst_plane)), .wdata(value),
		.raddr(BAW'(dst_q)), .rdata(bias_rd));

	// Stage 1: products of the nine taps, registered.
	logic signed [31:0] prod_s1 [9];
	logic               vld_s1;
	always_ff @(posedge clk) begin
		for (int t = 0; t < 9; t++) begin
			prod_s1[t] <= $signed(pix_rd[t]) * $signed(wt_rd[t]);
		end
	end

	logic signed [ACC_W-1:0] tapsum;
	always_comb begin
		tapsum = '0;
		for (int t = 0; t < 9; t++) begin
			tapsum = tapsum + ACC_W'(prod_s1[t]);
		end
	end

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W+15:0] leak_q;
	logic rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= c3lr_pkg::ST_IDLE;
			plane_q  <= '0;
			rd_vld_q <= 1'b0;
			vld_s1   <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= (state_q == c3lr_pkg::ST_READ);
			vld_s1   <= rd_vld_q;
			last_s1  <= rd_vld_q && (plane_q == np_eff);
			if (is_comp) begin
				plane_q <= '0;
			end else if (state_q == c3lr_pkg::ST_READ) begin
				plane_q <= plane_q + 9'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_comp) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + tapsum;
		end else if (state_q == c3lr_pkg::ST_BIAS) begin
			acc_q <= acc_q + (ACC_W'($signed(bias_rd)) <<< c3lr_pkg::FRAC_BITS);
		end
		if (state_q == c3lr_pkg::ST_ACT) begin
			leak_q <= acc_q[ACC_W-1] ?
				(56'(acc_q) * 56'(c3lr_pkg::LEAK_NUM)) >>> c3lr_pkg::LEAK_SHIFT
				: 56'(acc_q);
		end
	end

	// Next state. Reads run for np planes; then the pipeline drains.
	always_comb begin
		state_d = state_q;
		case (state_q)
			c3lr_pkg::ST_IDLE: if (is_comp) state_d = c3lr_pkg::ST_READ;
			c3lr_pkg::ST_READ: if (plane_q + 9'd1 == np_eff) state_d = c3lr_pkg::ST_ACC;
			c3lr_pkg::ST_ACC:  if (last_s1) state_d = c3lr_pkg::ST_BIAS;
			c3lr_pkg::ST_BIAS: state_d = c3lr_pkg::ST_ACT;
			c3lr_pkg::ST_ACT:  state_d = c3lr_pkg::ST_OUT;
			c3lr_pkg::ST_OUT:  if (out_ready) state_d = c3lr_pkg::ST_IDLE;
			default:           state_d = c3lr_pkg::ST_IDLE;
		endcase
	end

	// Final scaling and saturation of the registered value.
	logic signed [ACC_W+15:0] qv;
	assign qv = leak_q >>> c3lr_pkg::FRAC_BITS;
	assign out_valid = (state_q == c3lr_pkg::ST_OUT);
	assign res_plane = dst_q;
	assign res_col   = col_q;
	assign res_row   = row_q;
	always_comb begin
		saturated = 1'b1;
		if (qv > 56'sd32767) pixel_out = 16'sh7FFF;
		else if (qv < -56'sd32768) pixel_out = 16'sh8000;
		else begin
			pixel_out = qv[15:0];
			saturated = 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		last_s1 |-> vld_s1) else $error("last plane without data");
`endif

endmodule

[verif/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the 3x3 convolution layer
// Drives write and compute commands with random gaps, predicts each output
// pixel in a scoreboard class, and compares every returned field.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 40;

	// One command on the input channel.
	typedef struct {
		c3lr_pkg::cmd_t     command;
		logic [4:0]         src_plane;
		logic [4:0]         dst_plane;
		logic [5:0]         col;
		logic [5:0]         row;
		logic [3:0]         tap;
		logic signed [15:0] value;
	} layer_cmd_t;

	// One expected output pixel.
	typedef struct {
		logic [4:0]         plane;
		logic [5:0]         col;
		logic [5:0]         row;
		logic signed [15:0] pixel;
		logic               sat;
	} out_pixel_t;

	// Scoreboard: keeps its own copy of the three stores and the registers,
	// computes the activated pixel for every accepted compute of a plane in
	// use, and checks results in order.
	class layer_scoreboard;
		logic signed [15:0] pix_mem [32][64][64];
		logic signed [15:0] wt_mem [32][32][9];
		logic signed [15:0] bias_mem [32];
		bit pix_set [32][64][64];
		bit wt_set [32][32][9];
		bit bias_set [32];
		int eff_w = 64;
		int eff_h = 64;
		int eff_in = 1;
		int out_used = 1;
		out_pixel_t pixels_due [$];
		int errors = 0;

		function int clip(int v, int hi);
			if (v < 1)
				return 1;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function void set_reg(c3lr_pkg::reg_t idx, logic [6:0] data);
			case (idx)
				c3lr_pkg::REG_WIDTH:      eff_w = clip(int'(data), 64);
				c3lr_pkg::REG_HEIGHT:     eff_h = clip(int'(data), 64);
				c3lr_pkg::REG_IN_PLANES:  eff_in = clip(int'(data[5:0]), 32);
				c3lr_pkg::REG_OUT_PLANES: out_used = int'(data[5:0]);
				default: ;
			endcase
		endfunction

		function void note_command(layer_cmd_t c);
			longint acc;
			longint q;
			int r;
			int cc;
			out_pixel_t e;
			case (c.command)
				c3lr_pkg::CMD_PIXEL: begin
					pix_mem[c.src_plane][c.row][c.col] = c.value;
					pix_set[c.src_plane][c.row][c.col] = 1;
				end
				c3lr_pkg::CMD_WEIGHT: begin
					// Taps nine to fifteen lie beyond the store and are dropped.
					if (c.tap < c3lr_pkg::TAPS) begin
						wt_mem[c.dst_plane][c.src_plane][c.tap] = c.value;
						wt_set[c.dst_plane][c.src_plane][c.tap] = 1;
					end
				end
				c3lr_pkg::CMD_BIAS: begin
					bias_mem[c.dst_plane] = c.value;
					bias_set[c.dst_plane] = 1;
				end
				default: begin
					if (int'(c.dst_plane) < out_used) begin
						acc = 0;
						for (int p = 0; p < eff_in; p++)
							for (int dy = -1; dy <= 1; dy++)
								for (int dx = -1; dx <= 1; dx++) begin
									r = int'(c.row) + dy;
									cc = int'(c.col) + dx;
									r = (r < 0) ? 0 : ((r >= eff_h) ? eff_h - 1 : r);
									cc = (cc < 0) ? 0 : ((cc >= eff_w) ? eff_w - 1 : cc);
									acc += longint'(pix_mem[p][r][cc]) *
										longint'(wt_mem[c.dst_plane][p][(dy + 1) * 3 + dx + 1]);
								end
						acc += longint'(bias_mem[c.dst_plane]) <<< c3lr_pkg::FRAC_BITS;
						// Leaky slope of 6554/65536; arithmetic shifts round toward minus infinity.
						if (acc < 0)
							acc = (acc * c3lr_pkg::LEAK_NUM) >>> c3lr_pkg::LEAK_SHIFT;
						q = acc >>> c3lr_pkg::FRAC_BITS;
						e.sat = 0;
						if (q > 32767) begin
							q = 32767;
							e.sat = 1;
						end
						if (q < -32768) begin
							q = -32768;
							e.sat = 1;
						end
						e.plane = c.dst_plane;
						e.col = c.col;
						e.row = c.row;
						e.pixel = q[15:0];
						pixels_due.push_back(e);
					end
				end
			endcase
		endfunction

		function void check_result(out_pixel_t got);
			out_pixel_t e;
			if (pixels_due.size() == 0) begin
				$error("unexpected result: plane %0d col %0d row %0d", got.plane, got.col, got.row);
				errors++;
				return;
			end
			e = pixels_due.pop_front();
			if (got.plane !== e.plane) begin
				$error("res_plane: expected %0d, got %0d", e.plane, got.plane);
				errors++;
			end
			if (got.col !== e.col) begin
				$error("res_col: expected %0d, got %0d", e.col, got.col);
				errors++;
			end
			if (got.row !== e.row) begin
				$error("res_row: expected %0d, got %0d", e.row, got.row);
				errors++;
			end
			if (got.pixel !== e.pixel) begin
				$error("pixel_out: expected %0d, got %0d", e.pixel, got.pixel);
				errors++;
			end
			if (got.sat !== e.sat) begin
				$error("saturated: expected %0d, got %0d", e.sat, got.sat);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [6:0]         cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         command = '0;
	logic [4:0]         src_plane = '0;
	logic [4:0]         dst_plane = '0;
	logic [5:0]         col = '0;
	logic [5:0]         row = '0;
	logic [3:0]         tap = '0;
	logic signed [15:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [4:0]         res_plane;
	logic [5:0]         res_col;
	logic [5:0]         res_row;
	logic signed [15:0] pixel_out;
	logic               saturated;

	layer_scoreboard sb = new();
	int cycles = 0;
	int sent = 0;
	bit long_hold = 0;

	conv3x3_multiplane_leaky_relu u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.src_plane (src_plane),
		.dst_plane (dst_plane),
		.col       (col),
		.row       (row),
		.tap       (tap),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_plane (res_plane),
		.res_col   (res_col),
		.res_row   (res_row),
		.pixel_out (pixel_out),
		.saturated (saturated)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Values lean toward the extremes and small magnitudes so that both
	// saturated and unclipped pixels show up, on both sides of zero.
	function automatic logic signed [15:0] rand_value();
		logic signed [15:0] v;
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 3))
					0: v = 16'sh7FFF;
					1: v = 16'sh8000;
					2: v = 16'sh0000;
					default: v = -16'sd1;
				endcase
			end
			1: v = 16'($signed($urandom_range(0, 128)) - 64);
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// Offers one command, after a random gap, and returns at the rising edge
	// where the transfer happens. The valid line is touched once per step.
	task automatic send(layer_cmd_t c);
		int gap;
		gap = $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		command = c.command;
		src_plane = c.src_plane;
		dst_plane = c.dst_plane;
		col = c.col;
		row = c.row;
		tap = c.tap;
		value = c.value;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_command(c);
		sent++;
	endtask

	// Pixel, weight or bias write with every field random.
	task automatic send_noise();
		layer_cmd_t c;
		c.command = c3lr_pkg::cmd_t'($urandom_range(0, 2));
		c.src_plane = 5'($urandom);
		c.dst_plane = 5'($urandom);
		c.col = 6'($urandom);
		c.row = 6'($urandom);
		c.tap = 4'($urandom);
		c.value = rand_value();
		send(c);
	endtask

	// A compute that reads only written entries: any store entry the pixel
	// would read and that was never written is loaded first.
	task automatic issue_compute(int dst, int x, int y);
		layer_cmd_t c;
		int r;
		int cc;
		c.src_plane = 5'($urandom);
		c.dst_plane = 5'(dst);
		c.tap = 4'($urandom_range(0, 8));
		c.col = 6'($urandom);
		c.row = 6'($urandom);
		if (dst < sb.out_used) begin
			for (int p = 0; p < sb.eff_in; p++)
				for (int dy = -1; dy <= 1; dy++)
					for (int dx = -1; dx <= 1; dx++) begin
						r = y + dy;
						cc = x + dx;
						r = (r < 0) ? 0 : ((r >= sb.eff_h) ? sb.eff_h - 1 : r);
						cc = (cc < 0) ? 0 : ((cc >= sb.eff_w) ? sb.eff_w - 1 : cc);
						if (!sb.pix_set[p][r][cc]) begin
							c.command = c3lr_pkg::CMD_PIXEL;
							c.src_plane = 5'(p);
							c.row = 6'(r);
							c.col = 6'(cc);
							c.value = rand_value();
							send(c);
						end
						if (!sb.wt_set[dst][p][(dy + 1) * 3 + dx + 1]) begin
							c.command = c3lr_pkg::CMD_WEIGHT;
							c.src_plane = 5'(p);
							c.tap = 4'((dy + 1) * 3 + dx + 1);
							c.value = rand_value();
							send(c);
						end
					end
			if (!sb.bias_set[dst]) begin
				c.command = c3lr_pkg::CMD_BIAS;
				c.value = rand_value();
				send(c);
			end
		end
		c.command = c3lr_pkg::CMD_COMPUTE;
		c.col = 6'(x);
		c.row = 6'(y);
		c.value = rand_value();
		send(c);
	endtask

	// Drops valid, waits for every pixel to come back and for the pipeline to
	// drain, so that the registers can be rewritten safely.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pixels_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(c3lr_pkg::reg_t idx, int data);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = 7'(data);
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, 7'(data));
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Result side: random stalls per transfer, plus one long hold-off that
	// lets the layer back up into its input channel. The long hold-off
	// starts only once a result is waiting.
	initial begin
		int stall;
		out_pixel_t got;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = $urandom_range(0, 5);
			if (long_hold) begin
				stall = 300;
				long_hold = 0;
				out_ready = 1'b0;
				while (!out_valid) @(negedge clk);
			end
			out_ready = (stall == 0);
			if (stall > 0) begin
				repeat (stall) @(negedge clk);
				out_ready = 1'b1;
			end
			do @(posedge clk); while (!out_valid);
			got.plane = res_plane;
			got.col = res_col;
			got.row = res_row;
			got.pixel = pixel_out;
			got.sat = saturated;
			sb.check_result(got);
		end
	end

	// Register settings per phase: width, height, input planes, output planes
	// and the number of items to send. The first phase keeps the reset values.
	// Zero and all-ones register values exercise the clamping of the sizes.
	int ph_w [7] = '{64, 1, 0, 2, 127, 5, 0};
	int ph_h [7] = '{64, 1, 0, 2, 127, 3, 0};
	int ph_in [7] = '{1, 1, 0, 63, 8, 3, 0};
	int ph_out [7] = '{1, 4, 0, 1, 63, 32, 0};
	int ph_items [7] = '{150, 120, 60, 250, 250, 200, 100};

	initial begin
		int start;
		int bx;
		int by;
		int x;
		int y;
		int dst;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed corners and edges with the reset frame, a compute for a
		// plane not in use, and one random pixel, weight or bias write.
		issue_compute(0, 0, 0);
		issue_compute(0, 63, 63);
		issue_compute(0, 63, 0);
		issue_compute(0, 0, 63);
		issue_compute(31, 10, 10);
		issue_compute(0, 1, 62);
		send_noise();

		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0) begin
				settle();
				if (ph == 6) begin
					ph_w[ph] = $urandom_range(1, 10);
					ph_h[ph] = $urandom_range(1, 10);
					ph_in[ph] = $urandom_range(1, 4);
					ph_out[ph] = $urandom_range(1, 32);
				end
				write_reg(c3lr_pkg::REG_WIDTH, ph_w[ph]);
				write_reg(c3lr_pkg::REG_HEIGHT, ph_h[ph]);
				write_reg(c3lr_pkg::REG_IN_PLANES, ph_in[ph]);
				write_reg(c3lr_pkg::REG_OUT_PLANES, ph_out[ph]);
			end
			// In the small-frame phase, where computes come often, the
			// receiver goes quiet for a long stretch while commands keep
			// coming.
			if (ph == 5)
				long_hold = 1;
			start = sent;
			// Positions cluster around a random spot so the stores fill slowly.
			bx = $urandom_range(0, 63);
			by = $urandom_range(0, 63);
			while (sent - start < ph_items[ph]) begin
				if ($urandom_range(0, 4) == 0) begin
					send_noise();
				end else begin
					if ($urandom_range(0, 3) == 0) begin
						x = $urandom_range(0, 63);
						y = $urandom_range(0, 63);
					end else begin
						x = (bx + $urandom_range(0, 3)) % 64;
						y = (by + $urandom_range(0, 3)) % 64;
					end
					if (ph_out[ph] > 0 && $urandom_range(0, 7) != 0)
						dst = $urandom_range(0, (ph_out[ph] > 32 ? 32 : ph_out[ph]) - 1);
					else
						dst = $urandom_range(0, 31);
					issue_compute(dst, x, y);
				end
			end
		end

		settle();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
